FILE: rtl/core/tsal_pkg.sv
// Package for the trajectory sampler: point record, action codes and table sizing.
// No dependencies.
`default_nettype none
package tsal_pkg;
  localparam int MaxPoints = 64;
  localparam int IdxW = $clog2(MaxPoints);
  localparam int CntW = $clog2(MaxPoints + 1);

  typedef enum logic [1:0] {
    ActClear  = 2'd0,
    ActAppend = 2'd1,
    ActQuery  = 2'd2,
    ActNone   = 2'd3
  } action_e;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [15:0] heading;
    logic [31:0]        arc;
    logic signed [15:0] spd;
  } point_t;
endpackage
`default_nettype wire

FILE: rtl/core/tsal_divider.sv
// Restoring divider: quotient of a 49-bit dividend by a 33-bit divisor, one bit per cycle.
// Depends on tsal_pkg for the house style only.
`default_nettype none
module tsal_divider (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [48:0] num_i,
  input  wire logic [32:0] den_i,
  output logic             done_o,
  output logic [16:0]      quot_o
);
  import tsal_pkg::*;

  logic [48:0] num_q, num_d;
  logic [33:0] rem_q, rem_d;
  logic [32:0] den_q, den_d;
  logic [16:0] quot_q, quot_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [33:0] trial;

  // The ratio is at most 65536, so only the low 17 quotient bits can be set;
  // still all 49 dividend bits are shifted through the remainder.
  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_o = 1'b0;
    trial  = {rem_q[32:0], num_q[48]};
    if (start_i) begin
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      quot_d = '0;
      cnt_d  = 6'd49;
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[47:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d  = trial - {1'b0, den_q};
        quot_d = {quot_q[15:0], 1'b1};
      end else begin
        rem_d  = trial;
        quot_d = {quot_q[15:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign quot_o = quot_d;
endmodule
`default_nettype wire

FILE: rtl/core/trajectory_sample_by_arc_length.sv
// Trajectory sampler by arc length. Clear and append return no result.
// A query reads the last and the first entry, scans one entry per cycle up to the matching
// segment, then runs a serial divider and four multiply and add passes on one shared
// 33x17 multiplier before the result is valid (directly for an empty table, after the
// first entry at or before the first point, after the full scan past the end), and the
// next transaction is taken in the cycle after the result is accepted. Reset empties the table.
`default_nettype none
module trajectory_sample_by_arc_length (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         action_i,
  input  wire logic signed [31:0] point_x_i,
  input  wire logic signed [31:0] point_y_i,
  input  wire logic signed [15:0] point_heading_i,
  input  wire logic [31:0]        point_arc_i,
  input  wire logic signed [15:0] point_speed_i,
  input  wire logic [31:0]        query_arc_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    found_o,
  output logic signed [31:0]      pose_x_o,
  output logic signed [31:0]      pose_y_o,
  output logic signed [15:0]      pose_heading_o,
  output logic [14:0]             speed_o,
  output logic [31:0]             path_length_o
);
  import tsal_pkg::*;

  typedef enum logic [7:0] {
    StIdle  = 8'b0000_0001,
    StLast  = 8'b0000_0010,
    StFirst = 8'b0000_0100,
    StScan  = 8'b0000_1000,
    StDiv   = 8'b0001_0000,
    StMul   = 8'b0010_0000,
    StAdd   = 8'b0100_0000,
    StOut   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  point_t mem [MaxPoints];
  point_t rd_q, a_q, b_q;
  logic [IdxW-1:0] rd_addr;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [31:0] q_q, len_q;
  logic [16:0] r_q;
  logic [1:0]  step_q;
  logic signed [49:0] prod_q;
  logic signed [32:0] delta;
  logic signed [49:0] prod;
  logic signed [49:0] rnd;
  logic signed [33:0] base, sum;
  logic signed [31:0] ox_q, oy_q;
  logic signed [15:0] oh_q;
  logic signed [16:0] os_q;
  logic found_q;
  logic div_start, div_done;
  logic [16:0] div_quot;
  logic [32:0] ds, num;
  logic signed [32:0] diff_arc;
  logic signed [16:0] spd_fin;
  logic acc_in;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);
  assign acc_in      = in_valid_i && in_ready_o;

  // The read is issued for the next index, so rd_q holds entry idx in each state.
  assign rd_addr = idx_d[IdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (acc_in && action_e'(action_i) == ActAppend && count_q < CntW'(MaxPoints))
      mem[count_q[IdxW-1:0]] <= '{point_x_i, point_y_i, point_heading_i, point_arc_i,
                                  point_speed_i};
    rd_q <= mem[rd_addr];
  end

  // Segment length and clamped numerator for the ratio, taken when the scan matches.
  always_comb begin
    diff_arc = $signed({1'b0, rd_q.arc}) - $signed({1'b0, a_q.arc});
    ds = (diff_arc < 33'sd1) ? 33'd1 : 33'(diff_arc);
    num = {1'b0, q_q} - {1'b0, a_q.arc};
    if (q_q < a_q.arc) num = '0;
    if (num > ds) num = ds;
  end

  tsal_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ({num[32:0], 16'd0}),
    .den_i   (ds),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Shared multiply and rounded add, one field per pass.
  always_comb begin
    unique case (step_q)
      2'd0: begin
        delta = 33'($signed(b_q.x)) - 33'($signed(a_q.x));
        base  = 34'($signed(a_q.x));
      end
      2'd1: begin
        delta = 33'($signed(b_q.y)) - 33'($signed(a_q.y));
        base  = 34'($signed(a_q.y));
      end
      2'd2: begin
        delta = 33'($signed(16'(b_q.heading - a_q.heading)));
        base  = 34'($signed(a_q.heading));
      end
      default: begin
        delta = 33'($signed(b_q.spd)) - 33'($signed(a_q.spd));
        base  = 34'($signed(a_q.spd));
      end
    endcase
    prod = 50'(delta) * $signed({33'd0, r_q});
    rnd  = prod_q + 50'sd32768;
    sum  = base + 34'(rnd >>> 16);
  end

  always_comb begin
    if (os_q[16]) spd_fin = '0;
    else          spd_fin = os_q;
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    div_start = 1'b0;
    unique case (state_q)
      StIdle: if (in_valid_i) begin
        unique case (action_e'(action_i))
          ActClear:  count_d = '0;
          ActAppend: if (count_q < CntW'(MaxPoints)) count_d = count_q + 1'b1;
          ActQuery: begin
            if (count_q == '0) state_d = StOut;
            else begin
              idx_d   = count_q - 1'b1;
              state_d = StLast;
            end
          end
          default: ;
        endcase
      end
      StLast: begin
        idx_d   = '0;
        state_d = StFirst;
      end
      StFirst: begin
        if (q_q <= rd_q.arc) state_d = StOut;
        else begin
          idx_d   = CntW'(1);
          state_d = (count_q == CntW'(1)) ? StOut : StScan;
        end
      end
      StScan: begin
        // rd_q holds entry idx and a_q the entry before it.
        if (q_q <= rd_q.arc) begin
          div_start = 1'b1;
          state_d   = StDiv;
        end else if (idx_q == count_q - CntW'(1)) state_d = StOut;
        else idx_d = idx_q + 1'b1;
      end
      StDiv: if (div_done) state_d = StMul;
      StMul: state_d = StAdd;
      StAdd: state_d = (step_q == 2'd3) ? StOut : StMul;
      StOut: if (out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  // The scan keeps a (start of the segment) and loads b (its end) on a match.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: begin
        q_q     <= query_arc_i;
        found_q <= (count_q != '0);
        len_q   <= '0;
        ox_q <= '0; oy_q <= '0; oh_q <= '0; os_q <= '0;
        step_q  <= '0;
      end
      StLast: begin
        len_q <= rd_q.arc;
        ox_q  <= rd_q.x;
        oy_q  <= rd_q.y;
        oh_q  <= rd_q.heading;
        os_q  <= '0;
      end
      StFirst: begin
        if (q_q <= rd_q.arc) begin
          ox_q <= rd_q.x;
          oy_q <= rd_q.y;
          oh_q <= rd_q.heading;
          os_q <= 17'(rd_q.spd);
        end
        a_q <= rd_q;
      end
      StScan: begin
        if (q_q <= rd_q.arc) b_q <= rd_q;
        else a_q <= rd_q;
      end
      StDiv: r_q <= div_quot;
      StMul: prod_q <= prod;
      StAdd: begin
        unique case (step_q)
          2'd0: ox_q <= sum[31:0];
          2'd1: oy_q <= sum[31:0];
          2'd2: oh_q <= sum[15:0];
          default: os_q <= sum[16:0];
        endcase
        step_q <= step_q + 2'd1;
      end
      default: ;
    endcase
  end

  assign found_o        = found_q;
  assign pose_x_o       = ox_q;
  assign pose_y_o       = oy_q;
  assign pose_heading_o = oh_q;
  assign speed_o        = spd_fin[14:0];
  assign path_length_o  = len_q;
endmodule
`default_nettype wire

FILE: tb/sv/tsal_checker.sv
// Checker for the trajectory sampler: keeps its own point table, predicts each query
// result and compares it with what the block delivers. Depends on tsal_pkg.
`default_nettype none
module tsal_checker (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_ready_i,
  input  wire logic [1:0]         action_i,
  input  wire logic signed [31:0] point_x_i,
  input  wire logic signed [31:0] point_y_i,
  input  wire logic signed [15:0] point_heading_i,
  input  wire logic [31:0]        point_arc_i,
  input  wire logic signed [15:0] point_speed_i,
  input  wire logic [31:0]        query_arc_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_ready_i,
  input  wire logic               found_i,
  input  wire logic signed [31:0] pose_x_i,
  input  wire logic signed [31:0] pose_y_i,
  input  wire logic signed [15:0] pose_heading_i,
  input  wire logic [14:0]        speed_i,
  input  wire logic [31:0]        path_length_i,
  output int                      fail_count_o,
  output int                      pending_o,
  output int                      sample_count_o
);
  import tsal_pkg::*;

  typedef struct packed {
    logic        found;
    logic [31:0] x;
    logic [31:0] y;
    logic [15:0] heading;
    logic [14:0] speed;
    logic [31:0] length;
  } pose_t;

  point_t track [MaxPoints];
  int     track_len;
  pose_t  pose_q[$];

  // Rounded Q1.16 scaling, floor((d * r + 32768) / 65536).
  function automatic longint lerp_step(longint d, longint r);
    longint p;
    p = d * r + 32768;
    if (p >= 0) return p / 65536;
    return -((-p + 65535) / 65536);
  endfunction

  function automatic logic [15:0] wrap_angle(longint v);
    return v[15:0];
  endfunction

  function automatic pose_t sample_track(logic [31:0] q);
    pose_t  res;
    longint ds, num, r, s;
    point_t a, b;
    res = '0;
    if (track_len == 0) return res;
    res.found = 1'b1;
    res.length = track[track_len-1].arc;
    if (q <= track[0].arc) begin
      s = track[0].spd;
      res.x = track[0].x;
      res.y = track[0].y;
      res.heading = track[0].heading;
      res.speed = (s < 0) ? 15'd0 : s[14:0];
      return res;
    end
    for (int i = 1; i < track_len; i++) begin
      if (q <= track[i].arc) begin
        a = track[i-1];
        b = track[i];
        ds = longint'(b.arc) - longint'(a.arc);
        if (ds < 1) ds = 1;
        num = longint'(q) - longint'(a.arc);
        if (num < 0) num = 0;
        if (num > ds) num = ds;
        r = (num * 65536) / ds;
        if (r > 65536) r = 65536;
        res.x = 32'(longint'(a.x) + lerp_step(longint'(b.x) - longint'(a.x), r));
        res.y = 32'(longint'(a.y) + lerp_step(longint'(b.y) - longint'(a.y), r));
        res.heading = wrap_angle(longint'(a.heading) + lerp_step(longint'(
          $signed(wrap_angle(longint'(b.heading) - longint'(a.heading)))), r));
        s = longint'(a.spd) + lerp_step(longint'(b.spd) - longint'(a.spd), r);
        res.speed = (s < 0) ? 15'd0 : (s > 32767) ? 15'h7fff : s[14:0];
        return res;
      end
    end
    res.x = track[track_len-1].x;
    res.y = track[track_len-1].y;
    res.heading = track[track_len-1].heading;
    res.speed = '0;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pose_t  want;
    point_t p;
    if (!rst_ni) begin
      track_len <= 0;
      fail_count_o <= 0;
      sample_count_o <= 0;
      pending_o <= 0;
      pose_q.delete();
    end else begin
      if (in_valid_i && in_ready_i) begin
        case (action_e'(action_i))
          ActClear: track_len <= 0;
          ActAppend: begin
            if (track_len < MaxPoints) begin
              p.x = point_x_i;
              p.y = point_y_i;
              p.heading = point_heading_i;
              p.arc = point_arc_i;
              p.spd = point_speed_i;
              track[track_len] <= p;
              track_len <= track_len + 1;
            end
          end
          ActQuery: pose_q = {pose_q, sample_track(query_arc_i)};
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        sample_count_o <= sample_count_o + 1;
        if (pose_q.size() == 0) begin
          $error("result with no query outstanding");
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = pose_q.pop_front();
          if (found_i !== want.found || pose_x_i !== want.x || pose_y_i !== want.y ||
              pose_heading_i !== want.heading || speed_i !== want.speed ||
              path_length_i !== want.length) begin
            fail_count_o <= fail_count_o + 1;
            if (found_i !== want.found)
              $error("found: expected %0d, got %0d", want.found, found_i);
            if (pose_x_i !== want.x)
              $error("pose_x: expected %0d, got %0d", $signed(want.x), pose_x_i);
            if (pose_y_i !== want.y)
              $error("pose_y: expected %0d, got %0d", $signed(want.y), pose_y_i);
            if (pose_heading_i !== want.heading)
              $error("pose_heading: expected %0d, got %0d", $signed(want.heading),
                     pose_heading_i);
            if (speed_i !== want.speed)
              $error("speed: expected %0d, got %0d", want.speed, speed_i);
            if (path_length_i !== want.length)
              $error("path_length: expected %0d, got %0d", want.length, path_length_i);
          end
        end
      end
      pending_o <= pose_q.size();
    end
  end
endmodule
`default_nettype wire

FILE: tb/sv/tb_trajectory_sample_by_arc_length.sv
// Top of the trajectory sampler testbench: clock, reset, random stimulus and verdict.
// Depends on tsal_pkg, the block and tsal_checker.
`default_nettype none
module tb_trajectory_sample_by_arc_length;
  import tsal_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [1:0]         action_i = ActNone;
  logic signed [31:0] point_x_i = '0;
  logic signed [31:0] point_y_i = '0;
  logic signed [15:0] point_heading_i = '0;
  logic [31:0]        point_arc_i = '0;
  logic signed [15:0] point_speed_i = '0;
  logic [31:0]        query_arc_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic               found_o;
  logic signed [31:0] pose_x_o, pose_y_o;
  logic signed [15:0] pose_heading_o;
  logic [14:0]        speed_o;
  logic [31:0]        path_length_o;
  int                 fail_count, pending, sample_count;

  bit                 calm_phase = 1'b0;
  bit                 hold_off = 1'b0;
  logic [31:0]        arc_cursor = '0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  trajectory_sample_by_arc_length DUT (.*);

  tsal_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .action_i, .point_x_i,
    .point_y_i, .point_heading_i, .point_arc_i, .point_speed_i, .query_arc_i,
    .out_valid_i(out_valid_o), .out_ready_i, .found_i(found_o), .pose_x_i(pose_x_o),
    .pose_y_i(pose_y_o), .pose_heading_i(pose_heading_o), .speed_i(speed_o),
    .path_length_i(path_length_o), .fail_count_o(fail_count), .pending_o(pending),
    .sample_count_o(sample_count)
  );

  // Receiver: random stalls, none in the calm phase, a long hold-off on request.
  always @(posedge clk_i) begin
    out_ready_i <= !hold_off && (calm_phase || $urandom_range(99) >= 31);
  end

  // One transaction; valid stays up until accepted, with random idle cycles between.
  // Ready only changes at the rising edge, so its value at the falling edge is the one
  // seen by the next rising edge.
  task automatic send(action_e act, logic [31:0] px, logic [31:0] py, logic [15:0] ph,
                      logic [31:0] pa, logic [15:0] ps, logic [31:0] qa);
    bit taken;
    while (!calm_phase && $urandom_range(99) < 31) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    point_x_i <= px;
    point_y_i <= py;
    point_heading_i <= ph;
    point_arc_i <= pa;
    point_speed_i <= ps;
    query_arc_i <= qa;
    forever begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
      if (taken) break;
    end
  endtask

  task automatic add_point(logic [31:0] arc);
    send(ActAppend, $urandom, $urandom, 16'($urandom), arc, 16'($urandom), $urandom);
  endtask

  task automatic ask(logic [31:0] q);
    send(ActQuery, $urandom, $urandom, 16'($urandom), $urandom, 16'($urandom), q);
  endtask

  // A well-formed path of n points with nondecreasing arc, sometimes noisy.
  task automatic build_path(int n, bit messy);
    send(ActClear, '0, '0, '0, '0, '0, '0);
    arc_cursor = $urandom_range(3) == 0 ? $urandom : $urandom_range(1000);
    for (int i = 0; i < n; i++) begin
      if (messy && $urandom_range(3) == 0) add_point($urandom);
      else begin
        add_point(arc_cursor);
        arc_cursor = arc_cursor + ($urandom_range(4) == 0 ? 0 : $urandom_range(200000));
      end
    end
  endtask

  initial begin
    int n;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, single point, extremes, overfull table, unused action.
    ask('0);
    ask('1);
    send(ActAppend, 32'h8000_0000, 32'h7fff_ffff, 16'h8000, 32'd100, 16'h8000, '0);
    ask(32'd0);
    ask(32'd100);
    ask(32'hffff_ffff);
    send(ActAppend, 32'h7fff_ffff, 32'h8000_0000, 16'h7fff, 32'd100, 16'h7fff, '0);
    send(ActAppend, 32'h8000_0000, 32'h7fff_ffff, 16'h8000, 32'd50, 16'h7fff, '0);
    send(ActAppend, '1, '0, 16'h0001, 32'hffff_ffff, 16'hffff, '0);
    ask(32'd75);
    ask(32'd101);
    ask(32'h8000_0000);
    ask(32'hffff_fffe);
    send(ActNone, '1, '1, '1, '1, '1, '1);
    ask(32'hffff_ffff);
    for (int i = 0; i < MaxPoints + 2; i++) add_point(i * 1000);
    ask(32'd63500);
    ask(32'd64500);
    send(ActClear, '1, '1, '1, '1, '1, '1);
    ask(32'd5);

    // Hold the receiver off so queries back up and the input stalls.
    build_path(4, 1'b0);
    hold_off = 1'b1;
    fork
      begin
        repeat (600) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 6; i++) ask($urandom_range(arc_cursor));
    join

    // Random paths: mostly well formed, with noise; one long calm stretch.
    n = 0;
    while (n < 1150) begin
      int pts;
      calm_phase = (n > 400 && n < 550);
      pts = $urandom_range(9) == 0 ? $urandom_range(MaxPoints + 3) : $urandom_range(1, 8);
      build_path(pts, $urandom_range(4) == 0);
      n += pts + 1;
      repeat ($urandom_range(1, 5)) begin
        case ($urandom_range(9))
          0: ask($urandom);
          1: send(action_e'($urandom_range(3)), $urandom, $urandom, 16'($urandom),
                  $urandom, 16'($urandom), $urandom);
          default: ask($urandom_range(arc_cursor + 1000));
        endcase
        n++;
      end
    end
    in_valid_i <= 1'b0;
    calm_phase = 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("Ran %0d input transactions and checked %0d query results", n + 96,
             sample_count);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
`default_nettype wire

FILE: trajectory_sample_by_arc_length.f
rtl/core/tsal_pkg.sv
rtl/core/tsal_divider.sv
rtl/core/trajectory_sample_by_arc_length.sv
tb/sv/tsal_checker.sv
tb/sv/tb_trajectory_sample_by_arc_length.sv
